// ===== design/cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared constants and the luma function for the content bounding box.
// ----------------------------------------------------------------------------
package cbb_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DARK_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MARGIN         = 2'd1;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd2;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd3;

  // field widths
  localparam int unsigned PixW    = 8;
  localparam int unsigned ThrW    = 8;
  localparam int unsigned MarginW = 10;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned PosW    = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 13;

  // register reset values
  localparam logic [ThrW-1:0]    THRESHOLD_RESET = 8'd200;
  localparam logic [MarginW-1:0] MARGIN_RESET    = 10'd0;
  localparam logic [SizeW-1:0]   SIZE_RESET      = 13'd4096;

  // luma weights in 14-bit fixed point
  localparam int unsigned LumaShift = 14;
  localparam int unsigned LumaAccW  = 22;
  localparam logic [LumaAccW-1:0] WEIGHT_RED   = 22'd4899;
  localparam logic [LumaAccW-1:0] WEIGHT_GREEN = 22'd9617;
  localparam logic [LumaAccW-1:0] WEIGHT_BLUE  = 22'd1868;
  localparam logic [LumaAccW-1:0] LUMA_HALF    = 22'd8192;

  // rounded gray level of one bgr pixel
  function automatic logic [PixW-1:0] luma(input logic [PixW-1:0] b,
                                           input logic [PixW-1:0] g,
                                           input logic [PixW-1:0] r);
    logic [LumaAccW-1:0] acc;
    acc = LumaAccW'(b) * WEIGHT_BLUE + LumaAccW'(g) * WEIGHT_GREEN
        + LumaAccW'(r) * WEIGHT_RED + LUMA_HALF;
    return acc[LumaAccW-1:LumaShift];
  endfunction

endpackage

// ===== design/content_bounding_box.sv =====
// ----------------------------------------------------------------------------
// content_bounding_box
// Finds the padded bounding box of dark pixels in a raster-order bgr stream.
// ----------------------------------------------------------------------------
// One pixel is taken per clock with no gaps of its own making. A pixel passes
// three register stages: the gray compare is registered on entry, the position
// and extent trackers update in the second stage, and at the last pixel of a
// frame the extent is captured into a third stage whose padded, clamped box is
// registered onto the output. After the frame's last pixel is taken, its box
// passes the capture stage and the output register. The input stalls only when
// a frame result cannot move on because the output and the capture stage both
// still hold earlier results, which takes an output held long enough for two
// frame results to pile up. Configuration writes take effect at once; the user
// must make them between frames with the pipeline drained; it is not enforced.
module content_bounding_box #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [cbb_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [cbb_pkg::CfgW-1:0]          cfg_data_i,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cbb_pkg::PixW-1:0]          blue_i,
  input  logic [cbb_pkg::PixW-1:0]          green_i,
  input  logic [cbb_pkg::PixW-1:0]          red_i,
  // rectangle output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cbb_pkg::PosW-1:0]          box_left_o,
  output logic [cbb_pkg::PosW-1:0]          box_top_o,
  output logic [cbb_pkg::SizeW-1:0]         box_width_o,
  output logic [cbb_pkg::SizeW-1:0]         box_height_o,
  output logic                              content_found_o
);

  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned PosMx = (ColW > RowW) ? ColW : RowW;
  localparam int unsigned Base  = (PosMx > cbb_pkg::SizeW) ? PosMx : cbb_pkg::SizeW;
  localparam int unsigned CalcW = Base + 3;
  localparam logic [CalcW-1:0] MaxW  = CalcW'(MAX_WIDTH);
  localparam logic [CalcW-1:0] MaxH  = CalcW'(MAX_HEIGHT);
  localparam logic [CalcW-1:0] One   = CalcW'(1);

  // configuration registers
  logic [cbb_pkg::ThrW-1:0]    thr_q;
  logic [cbb_pkg::MarginW-1:0] margin_q;
  logic [cbb_pkg::SizeW-1:0]   fw_q, fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= cbb_pkg::THRESHOLD_RESET;
      margin_q <= cbb_pkg::MARGIN_RESET;
      fw_q     <= cbb_pkg::SIZE_RESET;
      fh_q     <= cbb_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbb_pkg::REG_DARK_THRESHOLD: thr_q    <= cfg_data_i[cbb_pkg::ThrW-1:0];
        cbb_pkg::REG_MARGIN:         margin_q <= cfg_data_i[cbb_pkg::MarginW-1:0];
        cbb_pkg::REG_FRAME_WIDTH:    fw_q     <= cfg_data_i[cbb_pkg::SizeW-1:0];
        cbb_pkg::REG_FRAME_HEIGHT:   fh_q     <= cfg_data_i[cbb_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, held between 1 and the maximum
  logic [CalcW-1:0] fw_x, fh_x, w_eff, h_eff;

  always_comb begin
    fw_x = CalcW'(fw_q);
    fh_x = CalcW'(fh_q);
    priority if (fw_x == '0) w_eff = One;
    else if (fw_x > MaxW)    w_eff = MaxW;
    else                     w_eff = fw_x;
    priority if (fh_x == '0) h_eff = One;
    else if (fh_x > MaxH)    h_eff = MaxH;
    else                     h_eff = fh_x;
  end

  // pipeline flow control
  logic a_v_q, a_dark_q;
  logic c_v_q;
  logic out_v_q;
  logic out_free, c_free, b_go, frame_end, row_end;

  assign out_free   = !out_v_q || out_ready_i;
  assign c_free     = !c_v_q || out_free;
  assign b_go       = a_v_q && (!frame_end || c_free);
  assign in_ready_o = !a_v_q || b_go;

  // stage a: gray compare of the incoming beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (in_ready_o) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_dark_q <= (cbb_pkg::luma(blue_i, green_i, red_i) <= thr_q);
    end
  end

  // stage b: position and extent tracking
  logic [ColW-1:0] col_q, col_d, lc_q, lc_d, gc_q, gc_d, lc_u, gc_u;
  logic [RowW-1:0] row_q, row_d, lr_q, lr_d, gr_q, gr_d, lr_u, gr_u;
  logic            any_q, any_d, any_u;

  assign row_end   = CalcW'(col_q) >= w_eff - One;
  assign frame_end = row_end && (CalcW'(row_q) >= h_eff - One);

  always_comb begin
    // extent including the current pixel
    lc_u  = lc_q;
    gc_u  = gc_q;
    lr_u  = lr_q;
    gr_u  = gr_q;
    any_u = any_q;
    if (a_dark_q) begin
      if (!any_q || col_q < lc_q) lc_u = col_q;
      if (!any_q || col_q > gc_q) gc_u = col_q;
      if (!any_q || row_q < lr_q) lr_u = row_q;
      if (!any_q || row_q > gr_q) gr_u = row_q;
      any_u = 1'b1;
    end

    col_d = col_q;
    row_d = row_q;
    lc_d  = lc_q;
    gc_d  = gc_q;
    lr_d  = lr_q;
    gr_d  = gr_q;
    any_d = any_q;
    if (b_go) begin
      priority if (frame_end) begin
        col_d = '0;
        row_d = '0;
        lc_d  = '1;
        gc_d  = '0;
        lr_d  = '1;
        gr_d  = '0;
        any_d = 1'b0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
        lc_d  = lc_u;
        gc_d  = gc_u;
        lr_d  = lr_u;
        gr_d  = gr_u;
        any_d = any_u;
      end else begin
        col_d = col_q + ColW'(1);
        lc_d  = lc_u;
        gc_d  = gc_u;
        lr_d  = lr_u;
        gr_d  = gr_u;
        any_d = any_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      lc_q  <= '1;
      gc_q  <= '0;
      lr_q  <= '1;
      gr_q  <= '0;
      any_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      lc_q  <= lc_d;
      gc_q  <= gc_d;
      lr_q  <= lr_d;
      gr_q  <= gr_d;
      any_q <= any_d;
    end
  end

  // stage c: extent captured at the end of a frame
  logic [ColW-1:0] c_lc_q, c_gc_q;
  logic [RowW-1:0] c_lr_q, c_gr_q;
  logic            c_any_q;
  logic            c_load;

  assign c_load = b_go && frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (c_load) begin
      c_v_q <= 1'b1;
    end else if (out_free) begin
      c_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_load) begin
      c_lc_q  <= lc_u;
      c_gc_q  <= gc_u;
      c_lr_q  <= lr_u;
      c_gr_q  <= gr_u;
      c_any_q <= any_u;
    end
  end

  // padded and clamped rectangle
  logic signed [CalcW-1:0] pad, lcs, gcs, lrs, grs, w_s, h_s;
  logic signed [CalcW-1:0] left, top, rem_w, rem_h, want_w, want_h, bw, bh;

  always_comb begin
    pad = $signed(CalcW'(margin_q));
    lcs = $signed(CalcW'(c_lc_q));
    gcs = $signed(CalcW'(c_gc_q));
    lrs = $signed(CalcW'(c_lr_q));
    grs = $signed(CalcW'(c_gr_q));
    w_s = $signed(w_eff);
    h_s = $signed(h_eff);
    left   = lcs - pad;
    top    = lrs - pad;
    rem_w  = '0;
    rem_h  = '0;
    want_w = (gcs - lcs) + $signed(One) + (pad <<< 1);
    want_h = (grs - lrs) + $signed(One) + (pad <<< 1);
    if (c_any_q) begin
      if (left < 0) left = '0;
      if (top < 0) top = '0;
      rem_w = w_s - left;
      rem_h = h_s - top;
      bw = (rem_w < want_w) ? rem_w : want_w;
      bh = (rem_h < want_h) ? rem_h : want_h;
      if (bw < 0) bw = '0;
      if (bh < 0) bh = '0;
    end else begin
      left = pad;
      top  = pad;
      bw   = pad <<< 1;
      bh   = pad <<< 1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && c_v_q) begin
      box_left_o      <= left[cbb_pkg::PosW-1:0];
      box_top_o       <= top[cbb_pkg::PosW-1:0];
      box_width_o     <= bw[cbb_pkg::SizeW-1:0];
      box_height_o    <= bh[cbb_pkg::SizeW-1:0];
      content_found_o <= c_any_q;
    end
  end

  assign out_valid_o = out_v_q;

  // checks
  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_load |=> (col_q == '0 && row_q == '0 && !any_q))
    else $error("tracking not cleared after frame end");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_v_q && frame_end && c_v_q && out_v_q))
    else $error("input stalled without a blocked frame result");

  a_extent_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> (lc_q <= gc_q && lr_q <= gr_q))
    else $error("content extent out of order");

  a_empty_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !content_found_o) |->
      (box_left_o == cbb_pkg::PosW'(margin_q) && box_top_o == cbb_pkg::PosW'(margin_q)))
    else $error("empty frame box does not sit at the margin");

endmodule

// ===== tb/cbb_box_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbb_box_checker
// Watches the pixel, rectangle and register ports of the content bounding
// box, works out each frame's padded box from the pixels it sees, and
// compares every rectangle beat with the oldest box still due.
// ----------------------------------------------------------------------------
module cbb_box_checker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cbb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cbb_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [cbb_pkg::PixW-1:0]    blue_i,
  input  logic [cbb_pkg::PixW-1:0]    green_i,
  input  logic [cbb_pkg::PixW-1:0]    red_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [cbb_pkg::PosW-1:0]    box_left_i,
  input  logic [cbb_pkg::PosW-1:0]    box_top_i,
  input  logic [cbb_pkg::SizeW-1:0]   box_width_i,
  input  logic [cbb_pkg::SizeW-1:0]   box_height_i,
  input  logic                        content_found_i,
  output int                          err_o,
  output int                          open_o,
  output int                          boxes_o
);

  // gray weights, 14-bit fixed point with rounding
  localparam int K_RED   = 4899;
  localparam int K_GREEN = 9617;
  localparam int K_BLUE  = 1868;
  localparam int K_ROUND = 8192;
  localparam int K_SHIFT = 14;
  localparam int NO_EDGE = 4095;

  typedef struct packed {
    logic [cbb_pkg::PosW-1:0]  left;
    logic [cbb_pkg::PosW-1:0]  top;
    logic [cbb_pkg::SizeW-1:0] wid;
    logic [cbb_pkg::SizeW-1:0] hgt;
    logic                      found;
  } box_t;

  // register copies
  int thr_lvl, pad_px, wid_cfg, hgt_cfg;

  // scan position and dark extent of the current frame
  int col_pos, row_pos, col_lo, col_hi, row_lo, row_hi;
  bit dark_seen;

  box_t box_due_q[$];

  function automatic int clamp_side(input int v, input int lim);
    if (v < 1) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic clear_extent();
    col_pos   = 0;
    row_pos   = 0;
    col_lo    = NO_EDGE;
    col_hi    = 0;
    row_lo    = NO_EDGE;
    row_hi    = 0;
    dark_seen = 1'b0;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_o++;
    end
  endtask

  // track pixels, queue frame boxes, compare rectangle beats
  always @(posedge clk_i or negedge rst_ni) begin : watch
    int   gray, wlim, hlim, lft, tp, bw, bh;
    box_t want;
    if (!rst_ni) begin
      thr_lvl = int'(cbb_pkg::THRESHOLD_RESET);
      pad_px  = int'(cbb_pkg::MARGIN_RESET);
      wid_cfg = int'(cbb_pkg::SIZE_RESET);
      hgt_cfg = int'(cbb_pkg::SIZE_RESET);
      clear_extent();
      box_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cbb_pkg::REG_DARK_THRESHOLD: thr_lvl = int'(cfg_data_i[cbb_pkg::ThrW-1:0]);
          cbb_pkg::REG_MARGIN:         pad_px  = int'(cfg_data_i[cbb_pkg::MarginW-1:0]);
          cbb_pkg::REG_FRAME_WIDTH:    wid_cfg = int'(cfg_data_i);
          cbb_pkg::REG_FRAME_HEIGHT:   hgt_cfg = int'(cfg_data_i);
          default: ;
        endcase
      end

      // pixel beat
      if (in_valid_i && in_ready_i) begin
        gray = (int'(blue_i) * K_BLUE + int'(green_i) * K_GREEN + int'(red_i) * K_RED
               + K_ROUND) >> K_SHIFT;
        if (gray <= thr_lvl) begin
          if (!dark_seen || col_pos < col_lo) col_lo = col_pos;
          if (!dark_seen || col_pos > col_hi) col_hi = col_pos;
          if (!dark_seen || row_pos < row_lo) row_lo = row_pos;
          if (!dark_seen || row_pos > row_hi) row_hi = row_pos;
          dark_seen = 1'b1;
        end
        wlim = clamp_side(wid_cfg, MAX_WIDTH);
        hlim = clamp_side(hgt_cfg, MAX_HEIGHT);
        if (col_pos >= wlim - 1 && row_pos >= hlim - 1) begin
          // last pixel of the frame: padded box clipped to the image
          if (dark_seen) begin
            lft = col_lo - pad_px;
            tp  = row_lo - pad_px;
            if (lft < 0) lft = 0;
            if (tp < 0) tp = 0;
            bw = col_hi - col_lo + 1 + 2 * pad_px;
            bh = row_hi - row_lo + 1 + 2 * pad_px;
            if (wlim - lft < bw) bw = wlim - lft;
            if (hlim - tp < bh) bh = hlim - tp;
            if (bw < 0) bw = 0;
            if (bh < 0) bh = 0;
          end else begin
            lft = pad_px;
            tp  = pad_px;
            bw  = 2 * pad_px;
            bh  = 2 * pad_px;
          end
          want = '{left: 12'(lft), top: 12'(tp), wid: 13'(bw), hgt: 13'(bh),
                   found: dark_seen};
          box_due_q.push_back(want);
          clear_extent();
        end else if (col_pos >= wlim - 1) begin
          col_pos = 0;
          row_pos++;
        end else begin
          col_pos++;
        end
      end

      // rectangle beat
      if (out_valid_i && out_ready_i) begin
        if (box_due_q.size() == 0) begin
          $display("%0t: rectangle with no frame due: left %0d top %0d width %0d height %0d",
                   $time, box_left_i, box_top_i, box_width_i, box_height_i);
          err_o++;
        end else begin
          want = box_due_q.pop_front();
          boxes_o++;
          check_field("box_left", int'(want.left), int'(box_left_i));
          check_field("box_top", int'(want.top), int'(box_top_i));
          check_field("box_width", int'(want.wid), int'(box_width_i));
          check_field("box_height", int'(want.hgt), int'(box_height_i));
          check_field("content_found", int'(want.found), int'(content_found_i));
        end
      end
    end
    open_o = box_due_q.size();
  end

endmodule

// ===== tb/content_bounding_box_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// content_bounding_box_tb
// Streams BGR frames of many shapes and register settings through the
// content bounding box, with random gaps on both channels and one long
// output hold, and takes the verdict from the box checker.
// ----------------------------------------------------------------------------
module content_bounding_box_tb;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYC     = 10;
  localparam int HOLD_CYC      = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYC    = 8;
  localparam int RANDOM_PIXELS = 700;
  localparam int PHASE_PIXELS  = 60;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;
  typedef enum int {FR_EMPTY, FR_RECT, FR_NOISE, FR_SPECK, FR_CORNERS} frame_e;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [cbb_pkg::CfgIdxW-1:0] cfg_idx   = '0;
  logic [cbb_pkg::CfgW-1:0]    cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [cbb_pkg::PixW-1:0]    blue      = '0;
  logic [cbb_pkg::PixW-1:0]    green     = '0;
  logic [cbb_pkg::PixW-1:0]    red       = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [cbb_pkg::PosW-1:0]    box_left;
  logic [cbb_pkg::PosW-1:0]    box_top;
  logic [cbb_pkg::SizeW-1:0]   box_width;
  logic [cbb_pkg::SizeW-1:0]   box_height;
  logic                        content_found;

  int    err_cnt, open_cnt, box_cnt;
  idle_e idle_mode   = IDLE_NONE;
  bit    long_hold   = 1'b0;
  int    quiet       = 0;
  int    px_cnt      = 0;
  int    setting_cnt = 0;
  int    cur_thr     = 200;
  int    cur_w       = 4096;
  int    cur_h       = 4096;

  always #HALF_PERIOD clk = ~clk;

  content_bounding_box dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .blue_i         (blue),
    .green_i        (green),
    .red_i          (red),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .box_left_o     (box_left),
    .box_top_o      (box_top),
    .box_width_o    (box_width),
    .box_height_o   (box_height),
    .content_found_o(content_found)
  );

  cbb_box_checker u_box_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .blue_i         (blue),
    .green_i        (green),
    .red_i          (red),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .box_left_i     (box_left),
    .box_top_i      (box_top),
    .box_width_i    (box_width),
    .box_height_i   (box_height),
    .content_found_i(content_found),
    .err_o          (err_cnt),
    .open_o         (open_cnt),
    .boxes_o        (box_cnt)
  );

  // percent of cycles spent idle on the sending or the receiving side
  function automatic int idle_pct(input bit recv_side);
    if (idle_mode == IDLE_BOTH) return 28;
    if (recv_side && idle_mode == IDLE_RECV) return 62;
    if (!recv_side && idle_mode == IDLE_SEND) return 62;
    return 0;
  endfunction

  function automatic int eff_side(input int v);
    if (v < 1) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  // pixel whose components all sit on one side of the threshold
  function automatic logic [23:0] shade(input bit dark);
    int lo, hi;
    if (dark || cur_thr == 255) begin
      lo = 0;
      hi = cur_thr;
    end else begin
      lo = cur_thr + 1;
      hi = 255;
    end
    return {8'($urandom_range(hi, lo)), 8'($urandom_range(hi, lo)),
            8'($urandom_range(hi, lo))};
  endfunction

  // one pixel beat, {blue, green, red}; starts and ends at a falling edge
  task automatic push_px(input logic [23:0] px);
    while ($urandom_range(99, 0) < idle_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    blue     <= px[23:16];
    green    <= px[15:8];
    red      <= px[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    px_cnt++;
    @(negedge clk);
  endtask

  // wait for every due box, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (open_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_regs(input int thr, input int pad, input int w, input int h);
    cfg_we   <= 1'b1;
    cfg_idx  <= cbb_pkg::REG_DARK_THRESHOLD;
    cfg_data <= cbb_pkg::CfgW'(thr);
    @(negedge clk);
    cfg_idx  <= cbb_pkg::REG_MARGIN;
    cfg_data <= cbb_pkg::CfgW'(pad);
    @(negedge clk);
    cfg_idx  <= cbb_pkg::REG_FRAME_WIDTH;
    cfg_data <= cbb_pkg::CfgW'(w);
    @(negedge clk);
    cfg_idx  <= cbb_pkg::REG_FRAME_HEIGHT;
    cfg_data <= cbb_pkg::CfgW'(h);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_thr = thr;
    cur_w   = w;
    cur_h   = h;
    setting_cnt++;
  endtask

  // one whole frame in raster order
  task automatic send_frame(input frame_e kind);
    int ew, eh, c0, c1, r0, r1, r, c;
    logic [23:0] px;
    ew = eff_side(cur_w);
    eh = eff_side(cur_h);
    c0 = $urandom_range(ew - 1, 0);
    c1 = $urandom_range(ew - 1, c0);
    r0 = $urandom_range(eh - 1, 0);
    r1 = $urandom_range(eh - 1, r0);
    for (r = 0; r < eh; r++) begin
      for (c = 0; c < ew; c++) begin
        case (kind)
          FR_RECT:    px = shade(r >= r0 && r <= r1 && c >= c0 && c <= c1
                                 && $urandom_range(1, 0) == 1);
          FR_NOISE:   px = 24'($urandom);
          FR_SPECK:   px = shade(r == r0 && c == c0);
          FR_CORNERS: px = shade((r == 0 && c == 0) || (r == eh - 1 && c == ew - 1));
          default:    px = shade(1'b0);
        endcase
        push_px(px);
      end
    end
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= idle_pct(1'b1));
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int i, p, start_px, phase_px, thr_v, pad_v, w_v, h_v;
    repeat (RESET_CYC) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-pixel frames: component extremes, threshold edge, empty frame
    write_regs(100, 5, 0, 0);
    push_px({8'd0, 8'd0, 8'd0});
    push_px({8'd255, 8'd255, 8'd255});
    push_px({8'd255, 8'd0, 8'd0});
    push_px({8'd0, 8'd255, 8'd0});
    push_px({8'd0, 8'd0, 8'd255});
    push_px({8'd100, 8'd100, 8'd100});
    push_px({8'd101, 8'd101, 8'd101});
    settle();

    // resize mid-frame: row and frame end early, box lands past the new width
    write_regs(50, 0, 8, 4);
    for (i = 0; i < 13; i++) push_px(shade(i == 12));
    settle();
    write_regs(50, 0, 3, 2);
    push_px(shade(1'b0));
    settle();

    // long output hold against one-pixel frames so the input backs up
    write_regs($urandom_range(255, 0), $urandom_range(1023, 0), 0, 0);
    long_hold = 1'b1;
    repeat (40) push_px(24'($urandom));
    settle();

    // sizes given past the maximum: no early row or frame end, then a shrink
    pad_v = $urandom_range(7, 0);
    write_regs(128, pad_v, 8191, 0);
    for (i = 0; i < 20; i++) push_px(shade(i == 7));
    settle();
    write_regs(128, pad_v, 1, 0);
    push_px(shade(1'b0));
    settle();
    pad_v = $urandom_range(7, 0);
    write_regs(128, pad_v, 1, 8191);
    for (i = 0; i < 20; i++) push_px(shade(i == 5));
    settle();
    write_regs(128, pad_v, 1, 2);
    push_px(shade(1'b0));
    settle();

    // random settings and frames, rotating through the idle patterns
    start_px = px_cnt;
    for (p = 0; px_cnt - start_px < RANDOM_PIXELS; p++) begin
      idle_mode = idle_e'(p % 4);
      case ($urandom_range(4, 0))
        0:       thr_v = 0;
        1:       thr_v = 255;
        default: thr_v = $urandom_range(255, 0);
      endcase
      case ($urandom_range(5, 0))
        0:       pad_v = 0;
        1:       pad_v = 1023;
        2:       pad_v = $urandom_range(1023, 0);
        default: pad_v = $urandom_range(3, 0);
      endcase
      w_v = ($urandom_range(5, 0) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 0);
      h_v = $urandom_range(8, 0);
      write_regs(thr_v, pad_v, w_v, h_v);
      phase_px = px_cnt;
      while (px_cnt - phase_px < PHASE_PIXELS) send_frame(frame_e'($urandom_range(4, 0)));
      settle();
    end

    idle_mode = IDLE_NONE;
    repeat (20) @(negedge clk);
    $display("run covered %0d pixels under %0d register settings, %0d boxes compared",
             px_cnt, setting_cnt, box_cnt);
    $display("incl. one-pixel frames, mid-frame resizes and sizes past the maximum");
    if (err_cnt == 0 && open_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== content_bounding_box.f =====
design/cbb_pkg.sv
design/content_bounding_box.sv
tb/cbb_box_checker.sv
tb/content_bounding_box_tb.sv
